### sv/ldpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpu_pkg
// Shared types, latencies and fixed-point helpers for the lens distortion
// project / unproject pipeline.
// ----------------------------------------------------------------------------
package ldpu_pkg;

    // Undistort rounds in the unproject path
    localparam int UNDISTORT_ITERATIONS = 5;

    // Divider: 33 quotient bits, one per stage, plus input and output stages
    localparam int DIV_STEPS  = 33;
    localparam int DIV_LAT    = DIV_STEPS + 2;

    // One undistort round: nine arithmetic stages, then the two dividers
    localparam int ITER_FRONT = 9;
    localparam int ITER_LAT   = ITER_FRONT + DIV_LAT;

    // Latencies measured from the input register
    localparam int PROJ_LAT   = 11;
    localparam int UNP_LAT    = 1 + DIV_LAT + UNDISTORT_ITERATIONS * ITER_LAT;
    localparam int PROJ_DLY   = UNP_LAT - PROJ_LAT;

    localparam int CFG_IDX_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_XY      = 4'd0,
        REG_CENTER_XY     = 4'd1,
        REG_RADIAL_K1     = 4'd2,
        REG_RADIAL_K2     = 4'd3,
        REG_RADIAL_K3     = 4'd4,
        REG_TANGENTIAL_P1 = 4'd5,
        REG_TANGENTIAL_P2 = 4'd6,
        REG_MAX_RADIUS_SQ = 4'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_PROJECT   = 1'b0,
        OP_UNPROJECT = 1'b1
    } t_opcode;

    localparam logic signed [47:0] Q24_ONE  = 48'sd16777216;
    localparam logic signed [63:0] Q24_HALF = 64'sd8388608;
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

    // Clamped value with its saturation flag
    typedef struct packed {
        logic               sat;
        logic signed [31:0] v;
    } t_sat32;

    // Distortion coefficients, Q8.24
    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    // Request moving between undistort rounds
    typedef struct packed {
        logic               valid;
        logic               sat;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
    } t_itr;

    // One stage of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] dd;
        logic [32:0] q;
        logic [31:0] ad;
        logic        neg;
        logic        zero;
        logic        npos;
        logic        nneg;
        logic        ovf;
    } t_div_st;

    // Finished project result waiting for the unproject path to line up
    typedef struct packed {
        logic               op;
        logic               oom;
        logic               sat;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } t_proj_res;

    // Q8.24 product, rounded half up
    function automatic logic signed [39:0] mul_r(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + Q24_HALF;
        return p[63:24];
    endfunction

    // Clamp to signed 32 bits
    function automatic t_sat32 clamp32(input logic signed [47:0] v);
        t_sat32 r;
        if (v > 48'sd2147483647) begin
            r.sat = 1'b1;
            r.v   = S32_MAX;
        end else if (v < -48'sd2147483648) begin
            r.sat = 1'b1;
            r.v   = S32_MIN;
        end else begin
            r.sat = 1'b0;
            r.v   = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/ldpu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpu_div
// Pipelined signed divider: (num << 24) / den, truncated toward zero and
// clamped to 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ldpu_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_num,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quot,
    output logic               o_sat
);
    import ldpu_pkg::*;

    t_div_st            r_st   [DIV_STEPS+1];
    t_div_st            n_st0;
    t_div_st            n_step [1:DIV_STEPS];
    logic [32:0]        w_an;
    logic [31:0]        w_ad;
    logic [32:0]        w_t    [1:DIV_STEPS];
    t_div_st            w_last;
    logic signed [31:0] n_quot;
    logic signed [31:0] r_quot;
    logic               n_sat;
    logic               r_sat;

    // Take magnitudes and check for a quotient of 2^33 or more
    always_comb begin
        w_an        = i_num[32] ? 33'(-i_num) : 33'(i_num);
        w_ad        = i_den[31] ? 32'(-i_den) : 32'(i_den);
        n_st0.rem   = {8'd0, w_an[32:9]};
        n_st0.dd    = {w_an[8:0], 24'd0};
        n_st0.q     = '0;
        n_st0.ad    = w_ad;
        n_st0.neg   = i_num[32] ^ i_den[31];
        n_st0.zero  = (i_den == 32'sd0);
        n_st0.npos  = !i_num[32] && (i_num != 33'sd0);
        n_st0.nneg  = i_num[32];
        n_st0.ovf   = ({8'd0, w_an[32:9]} >= w_ad);
    end

    // One restoring step per stage
    always_comb begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_t[k]         = {1'b0, r_st[k-1].rem[31:0]} << 1 | 33'(r_st[k-1].dd[32]);
            n_step[k]      = r_st[k-1];
            n_step[k].dd   = {r_st[k-1].dd[31:0], 1'b0};
            if (w_t[k] >= {1'b0, r_st[k-1].ad}) begin
                n_step[k].rem = 32'(w_t[k] - {1'b0, r_st[k-1].ad});
                n_step[k].q   = {r_st[k-1].q[31:0], 1'b1};
            end else begin
                n_step[k].rem = w_t[k][31:0];
                n_step[k].q   = {r_st[k-1].q[31:0], 1'b0};
            end
        end
    end

    // Apply sign, zero divisor and clamping
    always_comb begin
        w_last = r_st[DIV_STEPS];
        priority if (w_last.zero) begin
            n_sat  = 1'b1;
            n_quot = w_last.npos ? S32_MAX : (w_last.nneg ? S32_MIN : 32'sd0);
        end else if (w_last.ovf) begin
            n_sat  = 1'b1;
            n_quot = w_last.neg ? S32_MIN : S32_MAX;
        end else if (!w_last.neg) begin
            n_sat  = (w_last.q > 33'h0_7FFF_FFFF);
            n_quot = n_sat ? S32_MAX : w_last.q[31:0];
        end else begin
            n_sat  = (w_last.q > 33'h0_8000_0000);
            n_quot = n_sat ? S32_MIN : 32'(-w_last.q);
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_st[k] <= n_step[k];
            end
            r_quot <= n_quot;
            r_sat  <= n_sat;
        end
    end

    assign o_quot = r_quot;
    assign o_sat  = r_sat;

endmodule

### sv/ldpu_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpu_iter
// One undistort round: radial denominator and tangential offsets over nine
// stages, then x and y divided by the denominator.
// ----------------------------------------------------------------------------
module ldpu_iter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ldpu_pkg::t_coef i_coef,
    input  ldpu_pkg::t_itr  i_itr,
    output ldpu_pkg::t_itr  o_itr
);
    import ldpu_pkg::*;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
    } t_side;

    logic [ITER_FRONT:1] r_v;
    t_side               r_cr [1:ITER_FRONT];

    logic signed [39:0] r1_xx, r1_yy, r1_xy;
    logic signed [31:0] r2_xx, r2_yy, r2_xy;
    logic signed [31:0] r3_xx, r3_yy, r3_xy, r3_r2;
    logic signed [31:0] r4_r2, r4_tx, r4_ty;
    logic signed [39:0] r4_k3r2, r4_p1xy, r4_p2xy;
    logic signed [31:0] r5_r2, r5_a;
    logic signed [39:0] r5_p1xy, r5_p2xy, r5_p2tx, r5_p1ty;
    logic signed [31:0] r6_r2, r6_ddx, r6_ddy;
    logic signed [39:0] r6_ar2;
    logic signed [31:0] r7_r2, r7_b;
    logic signed [32:0] r7_nx, r7_ny;
    logic signed [39:0] r8_br2;
    logic signed [32:0] r8_nx, r8_ny;
    logic signed [31:0] r9_den;
    logic signed [32:0] r9_nx, r9_ny;

    t_sat32 c2_xx, c2_yy, c2_xy, c3_r2, c4_tx, c4_ty, c5_a, c6_ddx, c6_ddy;
    t_sat32 c7_b, c9_den;
    t_side  n_cr [1:ITER_FRONT];

    logic [DIV_LAT-1:0] r_sbv;
    t_side              r_sb [DIV_LAT];
    logic signed [31:0] w_qx, w_qy;
    logic               w_sx, w_sy;

    // Clamps between stages
    always_comb begin
        c2_xx  = clamp32(48'(r1_xx));
        c2_yy  = clamp32(48'(r1_yy));
        c2_xy  = clamp32(48'(r1_xy));
        c3_r2  = clamp32(48'(r2_xx) + 48'(r2_yy));
        c4_tx  = clamp32(48'(r3_r2) + (48'(r3_xx) <<< 1));
        c4_ty  = clamp32(48'(r3_r2) + (48'(r3_yy) <<< 1));
        c5_a   = clamp32(48'(r4_k3r2) + 48'(i_coef.k2));
        c6_ddx = clamp32((48'(r5_p1xy) <<< 1) + 48'(r5_p2tx));
        c6_ddy = clamp32(48'(r5_p1ty) + (48'(r5_p2xy) <<< 1));
        c7_b   = clamp32(48'(r6_ar2) + 48'(i_coef.k1));
        c9_den = clamp32(Q24_ONE + 48'(r8_br2));
    end

    // Carry the start point and saturation flag, folding in each stage's clamps
    always_comb begin
        n_cr[1].sat = i_itr.sat;
        n_cr[1].x0  = i_itr.x0;
        n_cr[1].y0  = i_itr.y0;
        for (int k = 2; k <= ITER_FRONT; k++) begin
            n_cr[k] = r_cr[k-1];
        end
        n_cr[2].sat = r_cr[1].sat | c2_xx.sat | c2_yy.sat | c2_xy.sat;
        n_cr[3].sat = r_cr[2].sat | c3_r2.sat;
        n_cr[4].sat = r_cr[3].sat | c4_tx.sat | c4_ty.sat;
        n_cr[5].sat = r_cr[4].sat | c5_a.sat;
        n_cr[6].sat = r_cr[5].sat | c6_ddx.sat | c6_ddy.sat;
        n_cr[7].sat = r_cr[6].sat | c7_b.sat;
        n_cr[9].sat = r_cr[8].sat | c9_den.sat;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_sbv <= '0;
        end else if (i_en) begin
            r_v   <= {r_v[ITER_FRONT-1:1], i_itr.valid};
            r_sbv <= {r_sbv[DIV_LAT-2:0], r_v[ITER_FRONT]};
        end
    end

    // Arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= ITER_FRONT; k++) begin
                r_cr[k] <= n_cr[k];
            end
            // squares and cross term
            r1_xx   <= mul_r(i_itr.x, i_itr.x);
            r1_yy   <= mul_r(i_itr.y, i_itr.y);
            r1_xy   <= mul_r(i_itr.x, i_itr.y);
            r2_xx   <= c2_xx.v;
            r2_yy   <= c2_yy.v;
            r2_xy   <= c2_xy.v;
            // radius squared
            r3_xx   <= r2_xx;
            r3_yy   <= r2_yy;
            r3_xy   <= r2_xy;
            r3_r2   <= c3_r2.v;
            // first Horner product and tangential products
            r4_r2   <= r3_r2;
            r4_tx   <= c4_tx.v;
            r4_ty   <= c4_ty.v;
            r4_k3r2 <= mul_r(i_coef.k3, r3_r2);
            r4_p1xy <= mul_r(i_coef.p1, r3_xy);
            r4_p2xy <= mul_r(i_coef.p2, r3_xy);
            r5_r2   <= r4_r2;
            r5_a    <= c5_a.v;
            r5_p1xy <= r4_p1xy;
            r5_p2xy <= r4_p2xy;
            r5_p2tx <= mul_r(i_coef.p2, r4_tx);
            r5_p1ty <= mul_r(i_coef.p1, r4_ty);
            // second Horner product, tangential offsets
            r6_r2   <= r5_r2;
            r6_ar2  <= mul_r(r5_a, r5_r2);
            r6_ddx  <= c6_ddx.v;
            r6_ddy  <= c6_ddy.v;
            r7_r2   <= r6_r2;
            r7_b    <= c7_b.v;
            r7_nx   <= 33'(r_cr[6].x0) - 33'(r6_ddx);
            r7_ny   <= 33'(r_cr[6].y0) - 33'(r6_ddy);
            // denominator
            r8_br2  <= mul_r(r7_b, r7_r2);
            r8_nx   <= r7_nx;
            r8_ny   <= r7_ny;
            r9_den  <= c9_den.v;
            r9_nx   <= r8_nx;
            r9_ny   <= r8_ny;
            // side data waiting on the dividers
            r_sb[0].sat <= r_cr[ITER_FRONT].sat;
            r_sb[0].x0  <= r_cr[ITER_FRONT].x0;
            r_sb[0].y0  <= r_cr[ITER_FRONT].y0;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    ldpu_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r9_nx),
        .i_den  (r9_den),
        .o_quot (w_qx),
        .o_sat  (w_sx)
    );

    ldpu_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r9_ny),
        .i_den  (r9_den),
        .o_quot (w_qy),
        .o_sat  (w_sy)
    );

    // r_sb[0] is loaded from stage nine at the edge the dividers take it,
    // so r_sb[DIV_LAT-1] lines up with the dividers' output
    assign o_itr.valid = r_sbv[DIV_LAT-1];
    assign o_itr.sat   = r_sb[DIV_LAT-1].sat | w_sx | w_sy;
    assign o_itr.x     = w_qx;
    assign o_itr.y     = w_qy;
    assign o_itr.x0    = r_sb[DIV_LAT-1].x0;
    assign o_itr.y0    = r_sb[DIV_LAT-1].y0;

endmodule

### sv/lens_distort_project_unproject.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_distort_project_unproject
// Five-coefficient radial/tangential lens model, camera plane to pixel and
// back, in one fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries opcode and a point; the
//   output channel o_out_valid / i_out_stall returns one result per request,
//   in order. A request moves on an edge with valid high and stall low.
//   Throughput is one request per cycle, both opcodes mixed, unless stalled.
//   Both opcodes take equally long from acceptance to o_out_valid; this
//   is dominated by the six chained divider levels of the unproject path
//   (the initial focal scaling and five undistort rounds, two lanes each),
//   each with 35 stages: input, one per quotient bit, output. Project
//   results are delayed to line up with unproject results.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   o_in_stall rises in the same cycle; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits and loads the register defaults:
//   focal lengths of 32'h0001_0000 each, zero center and coefficients, radius limit all ones.
//   Write configuration through i_cfg_we / i_cfg_idx / i_cfg_data only while
//   no request is in flight; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module lens_distort_project_unproject (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ldpu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic signed [31:0]                i_coord_x,
    input  logic signed [31:0]                i_coord_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_out_x,
    output logic signed [31:0]                o_out_y,
    output logic                              o_out_of_model,
    output logic                              o_saturated
);
    import ldpu_pkg::*;

    // Configuration registers
    logic [63:0]        r_focal_xy;
    logic [63:0]        r_center_xy;
    logic signed [31:0] r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [31:0]        r_max_radius_sq;

    logic               w_en;
    t_coef              w_coef;
    logic signed [31:0] w_fx, w_fy, w_cx, w_cy;

    // Input register
    logic               r_in_valid;
    logic               r_in_op;
    logic signed [31:0] r_in_x, r_in_y;

    // Unproject front: subtract center, divide by focal length
    logic               r_f_valid;
    logic signed [32:0] r_f_nx, r_f_ny;
    logic [DIV_LAT-1:0] r_fv;
    logic signed [31:0] w_fqx, w_fqy;
    logic               w_fsx, w_fsy;
    t_itr               w_chain [UNDISTORT_ITERATIONS+1];

    // Project path
    logic               r_p_op   [1:PROJ_LAT];
    logic               r_p_sat  [1:PROJ_LAT];
    logic signed [31:0] r_p_x    [1:PROJ_LAT-4];
    logic signed [31:0] r_p_y    [1:PROJ_LAT-4];
    logic               r2_oom;
    logic signed [39:0] r1_xx, r1_yy, r1_xy;
    logic signed [31:0] r2_xx, r2_yy, r2_xy;
    logic signed [31:0] r3_xx, r3_yy, r3_xy, r3_r2;
    logic signed [31:0] r4_r2, r4_r4, r4_tx, r4_ty, r4_xy;
    logic signed [39:0] r4_k1r2;
    logic signed [31:0] r5_r6;
    logic signed [39:0] r5_k1r2, r5_k2r4, r5_p1xy, r5_p2xy, r5_p2tx, r5_p1ty;
    logic signed [39:0] r6_k1r2, r6_k2r4, r6_k3r6;
    logic signed [39:0] r6_p1xy, r6_p2xy, r6_p2tx, r6_p1ty;
    logic signed [31:0] r7_f;
    logic signed [39:0] r7_p1xy, r7_p2xy, r7_p2tx, r7_p1ty;
    logic signed [39:0] r8_fx, r8_fy, r8_p1xy, r8_p2xy, r8_p2tx, r8_p1ty;
    logic signed [31:0] r9_dx, r9_dy;
    logic signed [39:0] r10_mx, r10_my;
    logic signed [31:0] r11_rx, r11_ry;
    logic               r3_oom, r4_oom, r5_oom, r6_oom, r7_oom, r8_oom;
    logic               r9_oom, r10_oom, r11_oom;
    logic signed [41:0] w_sum;

    t_sat32 c2_xx, c2_yy, c2_xy, c3_r2, c4_r4, c4_tx, c4_ty, c5_r6, c7_f;
    t_sat32 c9_dx, c9_dy, c11_rx, c11_ry;
    logic   n_p_sat [1:PROJ_LAT];

    t_proj_res          r_pd [PROJ_DLY];
    t_proj_res          w_pend;
    t_itr               w_uend;

    // Output register
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic               r_out_oom, r_out_sat;

    // Whole pipeline advances unless a finished result is held
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    assign w_fx = r_focal_xy[63:32];
    assign w_fy = r_focal_xy[31:0];
    assign w_cx = r_center_xy[63:32];
    assign w_cy = r_center_xy[31:0];
    assign w_coef.k1 = r_k1;
    assign w_coef.k2 = r_k2;
    assign w_coef.k3 = r_k3;
    assign w_coef.p1 = r_p1;
    assign w_coef.p2 = r_p2;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_xy      <= 64'h0001_0000_0001_0000;
            r_center_xy     <= '0;
            r_k1            <= '0;
            r_k2            <= '0;
            r_k3            <= '0;
            r_p1            <= '0;
            r_p2            <= '0;
            r_max_radius_sq <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FOCAL_XY:      r_focal_xy      <= i_cfg_data;
                REG_CENTER_XY:     r_center_xy     <= i_cfg_data;
                REG_RADIAL_K1:     r_k1            <= i_cfg_data[31:0];
                REG_RADIAL_K2:     r_k2            <= i_cfg_data[31:0];
                REG_RADIAL_K3:     r_k3            <= i_cfg_data[31:0];
                REG_TANGENTIAL_P1: r_p1            <= i_cfg_data[31:0];
                REG_TANGENTIAL_P2: r_p2            <= i_cfg_data[31:0];
                REG_MAX_RADIUS_SQ: r_max_radius_sq <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Control: valid bits of input, front and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_f_valid   <= 1'b0;
            r_fv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid  <= i_in_valid;
            r_f_valid   <= r_in_valid;
            r_fv        <= {r_fv[DIV_LAT-2:0], r_f_valid};
            r_out_valid <= w_uend.valid;
        end
    end

    // Capture request, form front numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_op <= i_opcode;
            r_in_x  <= i_coord_x;
            r_in_y  <= i_coord_y;
            r_f_nx  <= 33'(r_in_x) - 33'(w_cx);
            r_f_ny  <= 33'(r_in_y) - 33'(w_cy);
        end
    end

    ldpu_div u_div_fx (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_f_nx),
        .i_den  (w_fx),
        .o_quot (w_fqx),
        .o_sat  (w_fsx)
    );

    ldpu_div u_div_fy (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_f_ny),
        .i_den  (w_fy),
        .o_quot (w_fqy),
        .o_sat  (w_fsy)
    );

    // Start point of the undistort rounds
    assign w_chain[0].valid = r_fv[DIV_LAT-1];
    assign w_chain[0].sat   = w_fsx | w_fsy;
    assign w_chain[0].x     = w_fqx;
    assign w_chain[0].y     = w_fqy;
    assign w_chain[0].x0    = w_fqx;
    assign w_chain[0].y0    = w_fqy;

    for (genvar g = 0; g < UNDISTORT_ITERATIONS; g++) begin : g_iter
        ldpu_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_coef  (w_coef),
            .i_itr   (w_chain[g]),
            .o_itr   (w_chain[g+1])
        );
    end

    assign w_uend = w_chain[UNDISTORT_ITERATIONS];

    // Project path clamps
    always_comb begin
        w_sum  = 42'(r1_xx) + 42'(r1_yy);
        c2_xx  = clamp32(48'(r1_xx));
        c2_yy  = clamp32(48'(r1_yy));
        c2_xy  = clamp32(48'(r1_xy));
        c3_r2  = clamp32(48'(r2_xx) + 48'(r2_yy));
        c4_r4  = clamp32(48'(mul_r(r3_r2, r3_r2)));
        c4_tx  = clamp32(48'(r3_r2) + (48'(r3_xx) <<< 1));
        c4_ty  = clamp32(48'(r3_r2) + (48'(r3_yy) <<< 1));
        c5_r6  = clamp32(48'(mul_r(r4_r4, r4_r2)));
        c7_f   = clamp32(Q24_ONE + 48'(r6_k1r2) + 48'(r6_k2r4) + 48'(r6_k3r6));
        c9_dx  = clamp32(48'(r8_fx) + (48'(r8_p1xy) <<< 1) + 48'(r8_p2tx));
        c9_dy  = clamp32(48'(r8_fy) + 48'(r8_p1ty) + (48'(r8_p2xy) <<< 1));
        c11_rx = clamp32(48'(w_cx) + 48'(r10_mx));
        c11_ry = clamp32(48'(w_cy) + 48'(r10_my));
    end

    // Fold each stage's clamps into the saturation flag
    always_comb begin
        n_p_sat[1] = 1'b0;
        for (int k = 2; k <= PROJ_LAT; k++) begin
            n_p_sat[k] = r_p_sat[k-1];
        end
        n_p_sat[2]  = r_p_sat[1] | c2_xx.sat | c2_yy.sat | c2_xy.sat;
        n_p_sat[3]  = r_p_sat[2] | c3_r2.sat;
        n_p_sat[4]  = r_p_sat[3] | c4_r4.sat | c4_tx.sat | c4_ty.sat;
        n_p_sat[5]  = r_p_sat[4] | c5_r6.sat;
        n_p_sat[7]  = r_p_sat[6] | c7_f.sat;
        n_p_sat[9]  = r_p_sat[8] | c9_dx.sat | c9_dy.sat;
        n_p_sat[11] = r_p_sat[10] | c11_rx.sat | c11_ry.sat;
    end

    // Project stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_op[1]  <= r_in_op;
            r_p_x[1]   <= r_in_x;
            r_p_y[1]   <= r_in_y;
            for (int k = 1; k <= PROJ_LAT; k++) begin
                r_p_sat[k] <= n_p_sat[k];
            end
            for (int k = 2; k <= PROJ_LAT; k++) begin
                r_p_op[k] <= r_p_op[k-1];
            end
            for (int k = 2; k <= PROJ_LAT-4; k++) begin
                r_p_x[k] <= r_p_x[k-1];
                r_p_y[k] <= r_p_y[k-1];
            end
            // squares, cross term, radius limit
            r1_xx   <= mul_r(r_in_x, r_in_x);
            r1_yy   <= mul_r(r_in_y, r_in_y);
            r1_xy   <= mul_r(r_in_x, r_in_y);
            r2_oom  <= (w_sum > 42'sd0 + 42'(r_max_radius_sq));
            r2_xx   <= c2_xx.v;
            r2_yy   <= c2_yy.v;
            r2_xy   <= c2_xy.v;
            r3_oom  <= r2_oom;
            r3_xx   <= r2_xx;
            r3_yy   <= r2_yy;
            r3_xy   <= r2_xy;
            r3_r2   <= c3_r2.v;
            // even powers of the radius
            r4_oom  <= r3_oom;
            r4_r2   <= r3_r2;
            r4_r4   <= c4_r4.v;
            r4_tx   <= c4_tx.v;
            r4_ty   <= c4_ty.v;
            r4_xy   <= r3_xy;
            r4_k1r2 <= mul_r(r_k1, r3_r2);
            r5_oom  <= r4_oom;
            r5_r6   <= c5_r6.v;
            r5_k1r2 <= r4_k1r2;
            r5_k2r4 <= mul_r(r_k2, r4_r4);
            r5_p1xy <= mul_r(r_p1, r4_xy);
            r5_p2xy <= mul_r(r_p2, r4_xy);
            r5_p2tx <= mul_r(r_p2, r4_tx);
            r5_p1ty <= mul_r(r_p1, r4_ty);
            r6_oom  <= r5_oom;
            r6_k1r2 <= r5_k1r2;
            r6_k2r4 <= r5_k2r4;
            r6_k3r6 <= mul_r(r_k3, r5_r6);
            r6_p1xy <= r5_p1xy;
            r6_p2xy <= r5_p2xy;
            r6_p2tx <= r5_p2tx;
            r6_p1ty <= r5_p1ty;
            // distortion factor
            r7_oom  <= r6_oom;
            r7_f    <= c7_f.v;
            r7_p1xy <= r6_p1xy;
            r7_p2xy <= r6_p2xy;
            r7_p2tx <= r6_p2tx;
            r7_p1ty <= r6_p1ty;
            r8_oom  <= r7_oom;
            r8_fx   <= mul_r(r7_f, r_p_x[PROJ_LAT-4]);
            r8_fy   <= mul_r(r7_f, r_p_y[PROJ_LAT-4]);
            r8_p1xy <= r7_p1xy;
            r8_p2xy <= r7_p2xy;
            r8_p2tx <= r7_p2tx;
            r8_p1ty <= r7_p1ty;
            // distorted point, then pixels
            r9_oom  <= r8_oom;
            r9_dx   <= c9_dx.v;
            r9_dy   <= c9_dy.v;
            r10_oom <= r9_oom;
            r10_mx  <= mul_r(w_fx, r9_dx);
            r10_my  <= mul_r(w_fy, r9_dy);
            r11_oom <= r10_oom;
            r11_rx  <= c11_rx.v;
            r11_ry  <= c11_ry.v;
            // hold project results until the unproject path lines up
            r_pd[0].op  <= r_p_op[PROJ_LAT];
            r_pd[0].oom <= r11_oom;
            r_pd[0].sat <= r_p_sat[PROJ_LAT];
            r_pd[0].rx  <= r11_rx;
            r_pd[0].ry  <= r11_ry;
            for (int k = 1; k < PROJ_DLY; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    assign w_pend = r_pd[PROJ_DLY-1];

    // Pick the result for the request's opcode
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (t_opcode'(w_pend.op) == OP_PROJECT) begin
                r_out_x   <= w_pend.rx;
                r_out_y   <= w_pend.ry;
                r_out_oom <= w_pend.oom;
                r_out_sat <= w_pend.sat;
            end else begin
                r_out_x   <= w_uend.x;
                r_out_y   <= w_uend.y;
                r_out_oom <= 1'b0;
                r_out_sat <= w_uend.sat;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_of_model = r_out_oom;
    assign o_saturated    = r_out_sat;

endmodule
